>>> sv/fbed_pkg.sv
// Package for the field-bob edge-detecting deinterlacer.
// Holds lane geometry, register reset values, the register index codes and stage types.
// No dependencies.
`default_nettype none

package fbed_pkg;

    localparam int LANES      = 4;
    localparam int WORD_LANES = 4;
    localparam int ACT_LANES  = (LANES < WORD_LANES) ? LANES : WORD_LANES;
    localparam int LANE_W     = 16;
    localparam int WORD_W     = WORD_LANES * LANE_W;
    localparam int IN_W       = 3 * WORD_W;
    localparam int CFG_W      = 16;
    localparam int SQ_SHIFT   = 12;
    localparam int SQ_W       = 2;

    localparam logic [CFG_W-1:0] GAIN_RESET   = 16'd625;
    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd73;

    typedef enum logic {
        CFG_EDGE_GAIN        = 1'b0,
        CFG_JAGGIE_THRESHOLD = 1'b1
    } t_cfg_idx;

    // Stage 1 per lane: luma differences and the interpolated lane.
    typedef struct packed {
        logic signed [7:0]   d_am;
        logic signed [7:0]   d_bm;
        logic signed [7:0]   d_ab;
        logic [LANE_W-1:0]   avg;
    } t_s1_lane;

    // Stage 2 per lane: product and the coarse squared difference.
    typedef struct packed {
        logic signed [LANE_W-1:0] prod;
        logic [SQ_W-1:0]          sq;
        logic [LANE_W-1:0]        avg;
    } t_s2_lane;

endpackage

`default_nettype wire

>>> sv/field_bob_edge_deinterlace.sv
// An accepted request is registered in stage 1, stage 2 and the output register on its way to the master side.
// Throughput: one 64-bit group per cycle; the three stages (differences, products,
// score and select) each hold one request, and a stalled output holds the pipe.
// Reset (synchronous, active low) empties the pipe and loads edge_gain = 625 and
// jaggie_threshold = 73.
// Depends on fbed_pkg.
`default_nettype none

module field_bob_edge_deinterlace (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  fbed_pkg::t_cfg_idx           i_cfg_idx,
    input  wire [fbed_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [63:0] above_word, [127:64] middle_word, [191:128] below_word
    input  wire [fbed_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [63:0] result_word
    output logic [fbed_pkg::WORD_W-1:0]  m_axis_tdata
);

    localparam int NL = fbed_pkg::WORD_LANES;
    localparam int LW = fbed_pkg::LANE_W;
    localparam int WW = fbed_pkg::WORD_W;

    logic [fbed_pkg::CFG_W-1:0] r_gain;
    logic [fbed_pkg::CFG_W-1:0] r_thresh;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    fbed_pkg::t_s1_lane n_s1 [NL];
    fbed_pkg::t_s1_lane r_s1 [NL];
    fbed_pkg::t_s2_lane n_s2 [NL];
    fbed_pkg::t_s2_lane r_s2 [NL];
    logic [WW-1:0]      r_mid1, r_mid2;
    logic [WW-1:0]      n_out;
    logic [WW-1:0]      r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= fbed_pkg::GAIN_RESET;
            r_thresh <= fbed_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbed_pkg::CFG_EDGE_GAIN:        r_gain   <= i_cfg_data;
                fbed_pkg::CFG_JAGGIE_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage moves forward when it is empty or the stage after it moves.
    assign rdy3          = !r_v3 || m_axis_tready;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        logic [LW-1:0]            a, m, b;
        logic [7:0]               y1, e, y2;
        logic signed [LW-1:0]     sq_full;
        logic [LW-1:0]            pen;
        logic signed [LW-1:0]     score;
        logic                     interp;

        assign a  = s_axis_tdata[g*LW +: LW];
        assign m  = s_axis_tdata[WW + g*LW +: LW];
        assign b  = s_axis_tdata[2*WW + g*LW +: LW];
        assign y1 = {1'b0, a[7:1]};
        assign e  = {1'b0, m[7:1]};
        assign y2 = {1'b0, b[7:1]};

        // Stage 1: differences of the halved luma, per-byte average.
        always_comb begin
            n_s1[g].d_am = y1 - e;
            n_s1[g].d_bm = y2 - e;
            n_s1[g].d_ab = y1 - y2;
            n_s1[g].avg  = {1'b0, a[15:9], 1'b0, a[7:1]} + {1'b0, b[15:9], 1'b0, b[7:1]};
        end

        // Stage 2: signed products. The square is at most 127*127, so only
        // two bits are left above the shift.
        assign sq_full       = LW'(r_s1[g].d_ab * r_s1[g].d_ab);
        assign n_s2[g].prod  = LW'(r_s1[g].d_am * r_s1[g].d_bm);
        assign n_s2[g].sq    = sq_full[fbed_pkg::SQ_SHIFT +: fbed_pkg::SQ_W];
        assign n_s2[g].avg   = r_s1[g].avg;

        // Stage 3: penalty, wrapping score and signed compare.
        assign pen    = LW'({{(LW-fbed_pkg::SQ_W){1'b0}}, r_s2[g].sq} * r_gain);
        assign score  = r_s2[g].prod - $signed(pen);
        assign interp = (g < fbed_pkg::ACT_LANES) && (score > $signed(r_thresh));
        assign n_out[g*LW +: LW] = interp ? r_s2[g].avg : r_mid2[g*LW +: LW];

        always_ff @(posedge i_clk) begin
            if (rdy1 && s_axis_tvalid) r_s1[g] <= n_s1[g];
            if (rdy2 && r_v1)          r_s2[g] <= n_s2[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) r_mid1 <= s_axis_tdata[WW +: WW];
        if (rdy2 && r_v1)          r_mid2 <= r_mid1;
        if (rdy3 && r_v2)          r_out  <= n_out;
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

>>> sv/fbed_checker.sv
// Port-level checker for the field-bob edge-detecting deinterlacer, bound to the top level.
// Depends on fbed_pkg and field_bob_edge_deinterlace.
`default_nettype none

module fbed_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         s_axis_tvalid,
    input wire                         s_axis_tready,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [fbed_pkg::WORD_W-1:0]  m_axis_tdata
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // With no result waiting the whole pipe can move, so input is always taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output side is empty");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A rising result must follow an earlier request, a reset or an earlier result.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 3) || $past(s_axis_tvalid, 4)
            || !$past(i_rst_n, 3) || $past(m_axis_tvalid, 2) || $past(m_axis_tvalid, 3)
            || $past(s_axis_tvalid, 5) || $past(s_axis_tvalid, 6))
        else $error("result appeared without an earlier request");

endmodule

bind field_bob_edge_deinterlace fbed_checker u_fbed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
